### hdl/assert_macros.svh
// Assertion macros used by the port-level checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hdl/otc_pkg.sv
// Package: character codes, compound token codes and window/result types.
`timescale 1ns / 1ps

package otc_pkg;

    localparam int KIND_W = 10;

    // Trigger characters
    localparam logic [7:0] CH_EQ     = 8'h3D;  // =
    localparam logic [7:0] CH_BANG   = 8'h21;  // !
    localparam logic [7:0] CH_STAR   = 8'h2A;  // *
    localparam logic [7:0] CH_PCT    = 8'h25;  // %
    localparam logic [7:0] CH_CARET  = 8'h5E;  // ^
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
    localparam logic [7:0] CH_LT     = 8'h3C;  // <
    localparam logic [7:0] CH_GT     = 8'h3E;  // >
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
    localparam logic [7:0] CH_AMP    = 8'h26;  // &
    localparam logic [7:0] CH_PIPE   = 8'h7C;  // |
    localparam logic [7:0] CH_DOLLAR = 8'h24;  // $
    localparam logic [7:0] CH_AT     = 8'h40;  // @
    localparam logic [7:0] CH_HASH   = 8'h23;  // #
    localparam logic [7:0] CH_DOT    = 8'h2E;  // .
    localparam logic [7:0] CH_COLON  = 8'h3A;  // :
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
    localparam logic [7:0] CH_TILDE  = 8'h7E;  // ~
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    // Compound token codes
    localparam logic [KIND_W-1:0] K_EQ_EQ   = 10'h30B;
    localparam logic [KIND_W-1:0] K_NE      = 10'h30C;
    localparam logic [KIND_W-1:0] K_LE      = 10'h30D;
    localparam logic [KIND_W-1:0] K_GE      = 10'h30E;
    localparam logic [KIND_W-1:0] K_SHL     = 10'h309;
    localparam logic [KIND_W-1:0] K_SHR     = 10'h30A;
    localparam logic [KIND_W-1:0] K_SHL_EQ  = 10'h312;
    localparam logic [KIND_W-1:0] K_SHR_EQ  = 10'h313;
    localparam logic [KIND_W-1:0] K_INC     = 10'h305;
    localparam logic [KIND_W-1:0] K_DEC     = 10'h306;
    localparam logic [KIND_W-1:0] K_ARROW   = 10'h328;
    localparam logic [KIND_W-1:0] K_ADD_EQ  = 10'h319;
    localparam logic [KIND_W-1:0] K_SUB_EQ  = 10'h31A;
    localparam logic [KIND_W-1:0] K_LAND    = 10'h30F;
    localparam logic [KIND_W-1:0] K_LOR     = 10'h310;
    localparam logic [KIND_W-1:0] K_AND_EQ  = 10'h316;
    localparam logic [KIND_W-1:0] K_OR_EQ   = 10'h317;
    localparam logic [KIND_W-1:0] K_MUL_EQ  = 10'h314;
    localparam logic [KIND_W-1:0] K_MOD_EQ  = 10'h322;
    localparam logic [KIND_W-1:0] K_XOR_EQ  = 10'h318;
    localparam logic [KIND_W-1:0] K_DIV_EQ  = 10'h315;
    localparam logic [KIND_W-1:0] K_ELLIPSIS = 10'h324;
    localparam logic [KIND_W-1:0] K_SCOPE   = 10'h308;

    typedef struct packed {
        logic [7:0] byte_now;
        logic [7:0] byte_next;
        logic [7:0] byte_after;
        logic [1:0] bytes_left;
        logic       in_asm_block;
    } t_window;

    typedef struct packed {
        logic              is_operator;
        logic [KIND_W-1:0] token_kind;
        logic [1:0]        token_length;
    } t_token;

endpackage

### hdl/otc_match.sv
// Longest-match operator classifier over one three-byte window.
`timescale 1ns / 1ps

module otc_match (
    input  otc_pkg::t_window i_win,
    input  logic             i_multi_colon,
    output otc_pkg::t_token  o_tok
);
    import otc_pkg::*;

    logic [7:0]        c;
    logic [7:0]        n1;
    logic [7:0]        n2;
    logic [KIND_W-1:0] single;

    // Lookahead past the end reads as zero
    assign c      = i_win.byte_now;
    assign n1     = (i_win.bytes_left >= 2'd2) ? i_win.byte_next  : 8'h00;
    assign n2     = (i_win.bytes_left == 2'd3) ? i_win.byte_after : 8'h00;
    assign single = {2'b00, c};

    always_comb begin
        t_token one;
        t_token none;
        one  = '{is_operator: 1'b1, token_kind: single, token_length: 2'd1};
        none = '{is_operator: 1'b0, token_kind: '0, token_length: 2'd0};
        o_tok = none;
        if (i_win.bytes_left != 2'd0) begin
            case (c)
                CH_EQ:    o_tok = (n1 == CH_EQ) ? '{1'b1, K_EQ_EQ, 2'd2} : one;
                CH_BANG:  o_tok = (n1 == CH_EQ) ? '{1'b1, K_NE, 2'd2} : one;
                CH_STAR:  o_tok = (n1 == CH_EQ) ? '{1'b1, K_MUL_EQ, 2'd2} : one;
                CH_PCT:   o_tok = (n1 == CH_EQ) ? '{1'b1, K_MOD_EQ, 2'd2} : one;
                CH_CARET: o_tok = (n1 == CH_EQ) ? '{1'b1, K_XOR_EQ, 2'd2} : one;
                CH_SLASH: o_tok = (n1 == CH_EQ) ? '{1'b1, K_DIV_EQ, 2'd2} : one;
                CH_LT: begin
                    if (n1 == CH_EQ)      o_tok = '{1'b1, K_LE, 2'd2};
                    else if (n1 == CH_LT) o_tok = (n2 == CH_EQ) ? '{1'b1, K_SHL_EQ, 2'd3}
                                                                : '{1'b1, K_SHL, 2'd2};
                    else                  o_tok = one;
                end
                CH_GT: begin
                    if (n1 == CH_EQ)      o_tok = '{1'b1, K_GE, 2'd2};
                    else if (n1 == CH_GT) o_tok = (n2 == CH_EQ) ? '{1'b1, K_SHR_EQ, 2'd3}
                                                                : '{1'b1, K_SHR, 2'd2};
                    else                  o_tok = one;
                end
                CH_PLUS: begin
                    if (n1 == CH_PLUS)    o_tok = '{1'b1, K_INC, 2'd2};
                    else if (n1 == CH_EQ) o_tok = '{1'b1, K_ADD_EQ, 2'd2};
                    else                  o_tok = one;
                end
                CH_MINUS: begin
                    if (n1 == CH_MINUS)   o_tok = '{1'b1, K_DEC, 2'd2};
                    else if (n1 == CH_GT) o_tok = '{1'b1, K_ARROW, 2'd2};
                    else if (n1 == CH_EQ) o_tok = '{1'b1, K_SUB_EQ, 2'd2};
                    else                  o_tok = one;
                end
                CH_AMP: begin
                    if (n1 == CH_AMP)     o_tok = '{1'b1, K_LAND, 2'd2};
                    else if (n1 == CH_EQ) o_tok = '{1'b1, K_AND_EQ, 2'd2};
                    else                  o_tok = one;
                end
                CH_PIPE: begin
                    if (n1 == CH_PIPE)    o_tok = '{1'b1, K_LOR, 2'd2};
                    else if (n1 == CH_EQ) o_tok = '{1'b1, K_OR_EQ, 2'd2};
                    else                  o_tok = one;
                end
                CH_DOLLAR, CH_AT, CH_HASH: begin
                    if (i_win.in_asm_block) o_tok = one;
                end
                CH_DOT: begin
                    // a digit after the dot starts a number; ".." needs a third dot
                    if (n1 inside {[CH_0:CH_9]}) o_tok = none;
                    else if (n1 == CH_DOT)  o_tok = (n2 == CH_DOT) ? '{1'b1, K_ELLIPSIS, 2'd3}
                                                                   : none;
                    else                    o_tok = one;
                end
                CH_COLON: begin
                    if (i_multi_colon && n1 == CH_COLON) o_tok = '{1'b1, K_SCOPE, 2'd2};
                    else                                 o_tok = one;
                end
                CH_BSLASH, CH_TILDE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI,
                CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: o_tok = one;
                default: o_tok = none;
            endcase
        end
    end

endmodule

### hdl/operator_token_classifier_top.sv
// Top level: input register, operator classifier, result register.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                     payload
//  request   in         start & !busy                 i_byte_now, i_byte_next, i_byte_after,
//                                                     i_bytes_left, i_in_asm_block
//  result    out        o_valid (one-cycle strobe)    o_is_operator, o_token_kind,
//                                                     o_token_length
//  config    in         i_cfg_wr_en                   i_cfg_wr_data (multi-colon mode)
//
//  One request per cycle; each result strobes once its request has passed the input
//  register, the classifier logic and the result register.
//  busy is always low: nothing in the block holds a request off.
//  Synchronous active-low reset clears the valid flags and multi-colon mode.
//  The receiver cannot stall; a result is shown for exactly one cycle.

module operator_token_classifier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   i_byte_now,
    input  logic [7:0]                   i_byte_next,
    input  logic [7:0]                   i_byte_after,
    input  logic [1:0]                   i_bytes_left,
    input  logic                         i_in_asm_block,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_wr_data,
    output logic                         o_valid,
    output logic                         o_is_operator,
    output logic [otc_pkg::KIND_W-1:0]   o_token_kind,
    output logic [1:0]                   o_token_length
);
    import otc_pkg::*;

    logic    r_multi_colon;
    logic    r_in_valid;
    t_window r_win;
    t_window n_win;
    t_token  n_tok;
    logic    r_out_valid;
    t_token  r_tok;

    assign busy  = 1'b0;
    assign n_win = '{byte_now: i_byte_now, byte_next: i_byte_next,
                     byte_after: i_byte_after, bytes_left: i_bytes_left,
                     in_asm_block: i_in_asm_block};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multi_colon <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_multi_colon <= i_cfg_wr_data;
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    // payload registers advance every cycle
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_tok <= n_tok;
    end

    otc_match u_match (
        .i_win         (r_win),
        .i_multi_colon (r_multi_colon),
        .o_tok         (n_tok)
    );

    assign o_valid        = r_out_valid;
    assign o_is_operator  = r_tok.is_operator;
    assign o_token_kind   = r_tok.token_kind;
    assign o_token_length = r_tok.token_length;

endmodule

### hdl/otc_checker.sv
// Port-level checker for the operator token classifier, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module otc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic                       o_is_operator,
    input logic [otc_pkg::KIND_W-1:0] o_token_kind,
    input logic [1:0]                 o_token_length
);
    import otc_pkg::*;

    // every taken request yields exactly one strobe, through the input and result registers
    `ASSERT_ALWAYS(a_latency, i_clk, i_rst_n, o_valid == ($past(i_rst_n) && $past(i_rst_n, 2) && $past(start, 2) && !$past(busy, 2)))
    `ASSERT_IMPLIES(a_no_op_empty, i_clk, i_rst_n, o_valid && !o_is_operator, o_token_kind == '0 && o_token_length == 2'd0)
    `ASSERT_IMPLIES(a_op_len, i_clk, i_rst_n, o_valid && o_is_operator, o_token_length != 2'd0)
    `ASSERT_IMPLIES(a_single_kind, i_clk, i_rst_n, o_valid && o_token_length == 2'd1, o_token_kind[KIND_W-1:8] == '0)
    `ASSERT_IMPLIES(a_triple_kind, i_clk, i_rst_n, o_valid && o_token_length == 2'd3, o_token_kind == K_SHL_EQ || o_token_kind == K_SHR_EQ || o_token_kind == K_ELLIPSIS)

endmodule

bind operator_token_classifier_top otc_checker u_otc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_is_operator  (o_is_operator),
    .o_token_kind   (o_token_kind),
    .o_token_length (o_token_length)
);

### sim/otc_token_checker.sv
// Checker: watches requests, results and config writes, predicts each token and compares.
`timescale 1ns / 1ps

module otc_token_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [7:0]                 i_byte_now,
    input  logic [7:0]                 i_byte_next,
    input  logic [7:0]                 i_byte_after,
    input  logic [1:0]                 i_bytes_left,
    input  logic                       i_in_asm_block,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic                       o_valid,
    input  logic                       o_is_operator,
    input  logic [otc_pkg::KIND_W-1:0] o_token_kind,
    input  logic [1:0]                 o_token_length,
    output int                         fail_count,
    output int                         pending_tokens,
    output int                         operator_hits
);
    import otc_pkg::*;

    t_token expected_tokens[$];
    logic   scope_mode;

    function automatic t_token make_token(logic [KIND_W-1:0] kind, logic [1:0] len);
        t_token t;
        t.is_operator  = 1'b1;
        t.token_kind   = kind;
        t.token_length = len;
        return t;
    endfunction

    // First byte alone, or first byte plus '=' as the given compound code.
    function automatic t_token pick_eq(logic [7:0] c, logic [7:0] n1,
                                       logic [KIND_W-1:0] eq_kind);
        return (n1 == CH_EQ) ? make_token(eq_kind, 2'd2) : make_token({2'b00, c}, 2'd1);
    endfunction

    function automatic t_token classify_window(t_window w, logic scope_on);
        logic [7:0] c;
        logic [7:0] n1;
        logic [7:0] n2;
        t_token     t;
        c  = w.byte_now;
        n1 = (w.bytes_left >= 2'd2) ? w.byte_next : 8'h00;
        n2 = (w.bytes_left == 2'd3) ? w.byte_after : 8'h00;
        t  = '0;
        if (w.bytes_left == 2'd0)
            return t;
        case (c)
            CH_EQ:    t = pick_eq(c, n1, K_EQ_EQ);
            CH_BANG:  t = pick_eq(c, n1, K_NE);
            CH_STAR:  t = pick_eq(c, n1, K_MUL_EQ);
            CH_PCT:   t = pick_eq(c, n1, K_MOD_EQ);
            CH_CARET: t = pick_eq(c, n1, K_XOR_EQ);
            CH_SLASH: t = pick_eq(c, n1, K_DIV_EQ);
            CH_LT: begin
                if (n1 == CH_EQ)
                    t = make_token(K_LE, 2'd2);
                else if (n1 == CH_LT)
                    t = (n2 == CH_EQ) ? make_token(K_SHL_EQ, 2'd3) : make_token(K_SHL, 2'd2);
                else
                    t = make_token({2'b00, c}, 2'd1);
            end
            CH_GT: begin
                if (n1 == CH_EQ)
                    t = make_token(K_GE, 2'd2);
                else if (n1 == CH_GT)
                    t = (n2 == CH_EQ) ? make_token(K_SHR_EQ, 2'd3) : make_token(K_SHR, 2'd2);
                else
                    t = make_token({2'b00, c}, 2'd1);
            end
            CH_PLUS:  t = (n1 == CH_PLUS) ? make_token(K_INC, 2'd2) : pick_eq(c, n1, K_ADD_EQ);
            CH_MINUS: begin
                if (n1 == CH_MINUS)
                    t = make_token(K_DEC, 2'd2);
                else if (n1 == CH_GT)
                    t = make_token(K_ARROW, 2'd2);
                else
                    t = pick_eq(c, n1, K_SUB_EQ);
            end
            CH_AMP:   t = (n1 == CH_AMP) ? make_token(K_LAND, 2'd2) : pick_eq(c, n1, K_AND_EQ);
            CH_PIPE:  t = (n1 == CH_PIPE) ? make_token(K_LOR, 2'd2) : pick_eq(c, n1, K_OR_EQ);
            CH_DOLLAR, CH_AT, CH_HASH: begin
                if (w.in_asm_block)
                    t = make_token({2'b00, c}, 2'd1);
            end
            CH_DOT: begin
                // a digit after the dot starts a number; two dots need a third
                if (n1 >= CH_0 && n1 <= CH_9)
                    t = '0;
                else if (n1 == CH_DOT)
                    t = (n2 == CH_DOT) ? make_token(K_ELLIPSIS, 2'd3) : t_token'('0);
                else
                    t = make_token({2'b00, c}, 2'd1);
            end
            CH_COLON: begin
                if (scope_on && n1 == CH_COLON)
                    t = make_token(K_SCOPE, 2'd2);
                else
                    t = make_token({2'b00, c}, 2'd1);
            end
            CH_BSLASH, CH_TILDE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI,
            CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE:
                t = make_token({2'b00, c}, 2'd1);
            default: t = '0;
        endcase
        return t;
    endfunction

    always @(posedge i_clk) begin : l_watch
        t_window w;
        t_token  got;
        t_token  want;
        if (!i_rst_n) begin
            expected_tokens.delete();
            scope_mode = 1'b0;
        end else begin
            // results at this edge belong to earlier requests: check before taking a new one
            if (o_valid) begin
                got.is_operator  = o_is_operator;
                got.token_kind   = o_token_kind;
                got.token_length = o_token_length;
                if (expected_tokens.size() == 0) begin
                    $error("result with no request waiting: op=%b kind=%h len=%0d",
                           got.is_operator, got.token_kind, got.token_length);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.is_operator !== want.is_operator) begin
                        $error("is_operator: expected %b, actual %b",
                               want.is_operator, got.is_operator);
                        fail_count++;
                    end
                    if (got.token_kind !== want.token_kind) begin
                        $error("token_kind: expected %h, actual %h",
                               want.token_kind, got.token_kind);
                        fail_count++;
                    end
                    if (got.token_length !== want.token_length) begin
                        $error("token_length: expected %0d, actual %0d",
                               want.token_length, got.token_length);
                        fail_count++;
                    end
                    if (want.is_operator)
                        operator_hits++;
                end
            end
            if (start && !busy) begin
                w.byte_now     = i_byte_now;
                w.byte_next    = i_byte_next;
                w.byte_after   = i_byte_after;
                w.bytes_left   = i_bytes_left;
                w.in_asm_block = i_in_asm_block;
                expected_tokens.push_back(classify_window(w, scope_mode));
            end
            if (i_cfg_wr_en)
                scope_mode = i_cfg_wr_data;
        end
        pending_tokens = expected_tokens.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top: clock, reset, request stimulus, colon-mode writes and the verdict.
`timescale 1ns / 1ps

module tb_top;
    import otc_pkg::*;

    localparam int TIMEOUT_CYCLES  = 200000;
    localparam int ITEMS_PER_PHASE = 345;
    localparam int NUM_PHASES      = 4;
    localparam logic PHASE_SCOPE [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0};

    localparam logic [7:0] TRIGGER_BYTES [27] = '{
        CH_EQ, CH_BANG, CH_STAR, CH_PCT, CH_CARET, CH_SLASH, CH_LT, CH_GT, CH_PLUS,
        CH_MINUS, CH_AMP, CH_PIPE, CH_DOLLAR, CH_AT, CH_HASH, CH_DOT, CH_COLON,
        CH_BSLASH, CH_TILDE, CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI, CH_LBRACK,
        CH_RBRACK, CH_LBRACE, CH_RBRACE};
    localparam logic [7:0] FOLLOW_BYTES [9] = '{
        CH_EQ, CH_PLUS, CH_MINUS, CH_GT, CH_LT, CH_AMP, CH_PIPE, CH_DOT, CH_COLON};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [7:0]        i_byte_now;
    logic [7:0]        i_byte_next;
    logic [7:0]        i_byte_after;
    logic [1:0]        i_bytes_left;
    logic              i_in_asm_block;
    logic              i_cfg_wr_en;
    logic              i_cfg_wr_data;
    logic              o_valid;
    logic              o_is_operator;
    logic [KIND_W-1:0] o_token_kind;
    logic [1:0]        o_token_length;
    int                fail_count;
    int                pending_tokens;
    int                operator_hits;
    int                requests_sent;
    int                cycle_count;

    always #5ns i_clk = ~i_clk;

    operator_token_classifier_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_byte_now     (i_byte_now),
        .i_byte_next    (i_byte_next),
        .i_byte_after   (i_byte_after),
        .i_bytes_left   (i_bytes_left),
        .i_in_asm_block (i_in_asm_block),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .o_is_operator  (o_is_operator),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length)
    );

    otc_token_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_byte_now     (i_byte_now),
        .i_byte_next    (i_byte_next),
        .i_byte_after   (i_byte_after),
        .i_bytes_left   (i_bytes_left),
        .i_in_asm_block (i_in_asm_block),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_valid        (o_valid),
        .o_is_operator  (o_is_operator),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length),
        .fail_count     (fail_count),
        .pending_tokens (pending_tokens),
        .operator_hits  (operator_hits)
    );

    function automatic t_window mk_win(logic [7:0] now, logic [7:0] nxt, logic [7:0] aft,
                                       logic [1:0] left, logic asm_on);
        t_window w;
        w.byte_now     = now;
        w.byte_next    = nxt;
        w.byte_after   = aft;
        w.bytes_left   = left;
        w.in_asm_block = asm_on;
        return w;
    endfunction

    // Mostly operator-shaped windows, with some raw bytes and out-of-range cursors.
    function automatic t_window random_window();
        t_window w;
        w.byte_now = ($urandom_range(0, 3) != 0) ? TRIGGER_BYTES[$urandom_range(0, 26)]
                                                 : 8'($urandom);
        case ($urandom_range(0, 5))
            0, 1, 2: w.byte_next = FOLLOW_BYTES[$urandom_range(0, 8)];
            3:       w.byte_next = 8'(CH_0 + $urandom_range(0, 9));
            default: w.byte_next = 8'($urandom);
        endcase
        if ($urandom_range(0, 1) != 0)
            w.byte_after = ($urandom_range(0, 1) != 0) ? CH_EQ : CH_DOT;
        else
            w.byte_after = 8'($urandom);
        w.bytes_left   = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
        w.in_asm_block = 1'($urandom);
        return w;
    endfunction

    // Hold the request until it is taken; busy is sampled mid-cycle.
    task automatic send_req(t_window w);
        logic taken;
        start          <= 1'b1;
        i_byte_now     <= w.byte_now;
        i_byte_next    <= w.byte_next;
        i_byte_after   <= w.byte_after;
        i_bytes_left   <= w.bytes_left;
        i_in_asm_block <= w.in_asm_block;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        requests_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_tokens != 0);
        @(posedge i_clk);
    endtask

    task automatic write_scope_mode(logic value);
        wait_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin : l_timeout
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_tokens);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : l_stimulus
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_byte_now     <= 8'h00;
        i_byte_next    <= 8'h00;
        i_byte_after   <= 8'h00;
        i_bytes_left   <= 2'd0;
        i_in_asm_block <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, multi-colon mode at its reset value, then set for the last two requests
        send_req(mk_win(CH_EQ, CH_EQ, CH_EQ, 2'd0, 1'b1));
        send_req(mk_win(8'h00, 8'h00, 8'h00, 2'd3, 1'b0));
        send_req(mk_win(8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1));
        send_req(mk_win(CH_EQ, CH_EQ, 8'h78, 2'd3, 1'b0));
        send_req(mk_win(CH_BANG, CH_EQ, CH_EQ, 2'd1, 1'b0));
        send_req(mk_win(CH_LT, CH_LT, CH_EQ, 2'd3, 1'b0));
        send_req(mk_win(CH_LT, CH_LT, CH_EQ, 2'd2, 1'b0));
        send_req(mk_win(CH_GT, CH_GT, CH_EQ, 2'd3, 1'b0));
        send_req(mk_win(CH_GT, CH_EQ, 8'h00, 2'd2, 1'b0));
        send_req(mk_win(CH_MINUS, CH_GT, 8'h00, 2'd3, 1'b0));
        send_req(mk_win(CH_MINUS, CH_MINUS, 8'h00, 2'd2, 1'b0));
        send_req(mk_win(CH_PLUS, CH_PLUS, CH_EQ, 2'd3, 1'b0));
        send_req(mk_win(CH_AMP, CH_AMP, 8'h00, 2'd2, 1'b0));
        send_req(mk_win(CH_PIPE, CH_EQ, 8'h00, 2'd2, 1'b0));
        send_req(mk_win(CH_DOT, CH_0 + 8'd5, 8'h00, 2'd3, 1'b0));
        send_req(mk_win(CH_DOT, CH_DOT, 8'h78, 2'd3, 1'b0));
        send_req(mk_win(CH_DOT, CH_DOT, CH_DOT, 2'd3, 1'b0));
        send_req(mk_win(CH_DOT, CH_DOT, CH_DOT, 2'd2, 1'b0));
        send_req(mk_win(CH_DOT, CH_DOT, CH_DOT, 2'd1, 1'b0));
        send_req(mk_win(CH_DOLLAR, 8'h00, 8'h00, 2'd1, 1'b0));
        send_req(mk_win(CH_AT, 8'h00, 8'h00, 2'd1, 1'b1));
        send_req(mk_win(CH_BSLASH, CH_EQ, 8'h00, 2'd2, 1'b0));
        send_req(mk_win(CH_COLON, CH_COLON, 8'h00, 2'd3, 1'b0));
        write_scope_mode(1'b1);
        send_req(mk_win(CH_COLON, CH_COLON, 8'h00, 2'd3, 1'b0));
        send_req(mk_win(CH_COLON, CH_COLON, 8'h00, 2'd1, 1'b0));

        // random part; the last phase runs back to back
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_scope_mode(PHASE_SCOPE[ph]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 1 && k == ITEMS_PER_PHASE / 2)
                    wait_drained();
                if (ph < NUM_PHASES - 1 && $urandom_range(0, 7) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                end
                send_req(random_window());
            end
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending_tokens != 0);
        repeat (4) @(posedge i_clk);

        $display("Summary: %0d cursor windows classified over %0d colon-mode settings,",
                 requests_sent, NUM_PHASES + 2);
        $display("         %0d of them operator tokens, %0d field mismatches",
                 operator_hits, fail_count);
        if (fail_count == 0 && pending_tokens == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
